// ===== hw/rtl/bbd_pkg.sv =====
// Shared types, constants and helpers for the Bayer demosaic core.
`timescale 1ns / 1ps
package bbd_pkg;
  localparam int PIX_W      = 14;
  localparam int RAW_W      = 16;
  localparam int OUT_W      = 16;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BAYER_ORDER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    COL_RED  = 2'd0,
    COL_GR   = 2'd1,
    COL_GB   = 2'd2,
    COL_BLUE = 2'd3
  } color_t;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  // one entry per input item that emits at least one pixel
  typedef struct packed {
    window_t win;
    logic    cl_mirror;
    logic    ru_mirror;
    logic    r0;
    logic    c0;
    logic    wm1_0;
    logic    eol;
    logic    last_row;
  } job_t;

  // color at a position: order code xor {row parity, column parity}
  function automatic color_t color_at(input logic [1:0] order, input logic [1:0] pos);
    return color_t'(order ^ pos);
  endfunction
endpackage

// ===== hw/rtl/bbd_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module bbd_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/bbd_front.sv =====
// Front end: accepts raw items, runs line stores and window, builds emit jobs.
`timescale 1ns / 1ps
module bbd_front #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [bbd_pkg::RAW_W-1:0]          raw_pixel,
  input  logic                               restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    height_eff,
  output logic                               busy,
  output logic                               push,
  output bbd_pkg::job_t                      push_job
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WD = $clog2(MAX_WIDTH+1);
  localparam int HD = $clog2(MAX_HEIGHT+1);

  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [WD-1:0] wm1;
  logic [HD-1:0] hm1;
  logic          eol, lrow;

  logic [bbd_pkg::PIX_W-1:0] pix;
  logic [bbd_pkg::PIX_W-1:0] up_rd, mid_rd;

  logic                      s1_valid;
  logic [bbd_pkg::PIX_W-1:0] s1_pix;
  logic [CW-1:0]             s1_col;
  logic                      s1_emit, s1_cl, s1_ru, s1_r0, s1_c0, s1_wm1_0, s1_eol, s1_lrow;

  bbd_pkg::window_t win, win_next;

  assign pix  = raw_pixel[bbd_pkg::RAW_W-1 -: bbd_pkg::PIX_W];
  assign wm1  = width_eff - WD'(1);
  assign hm1  = height_eff - HD'(1);
  assign eol  = (WD'(col) == wm1);
  assign lrow = (HD'(row) == hm1);
  assign busy = s1_valid;

  always_comb begin
    col_next = col + CW'(1);
    row_next = row;
    if (eol) begin
      col_next = '0;
      row_next = lrow ? '0 : row + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // middle store written on accept; upper store takes the old middle in the next cycle
  bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_mid (
    .clk(clk), .we(accept), .waddr(col), .wdata(pix), .raddr(col), .rdata(mid_rd)
  );
  bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_up (
    .clk(clk), .we(s1_valid), .waddr(s1_col), .wdata(mid_rd), .raddr(col), .rdata(up_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pix   <= pix;
      s1_col   <= col;
      s1_emit  <= (row != '0) && (col != '0);
      s1_cl    <= (col == CW'(1));
      s1_ru    <= (row == RW'(1));
      s1_r0    <= row[0];
      s1_c0    <= col[0];
      s1_wm1_0 <= wm1[0];
      s1_eol   <= eol;
      s1_lrow  <= lrow;
    end
  end

  always_comb begin
    win_next = win;
    if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        win_next[i][0] = win[i][1];
        win_next[i][1] = win[i][2];
      end
      win_next[0][2] = up_rd;
      win_next[1][2] = mid_rd;
      win_next[2][2] = s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else begin
      win <= win_next;
    end
  end

  assign push               = s1_valid && s1_emit;
  assign push_job.win       = win_next;
  assign push_job.cl_mirror = s1_cl;
  assign push_job.ru_mirror = s1_ru;
  assign push_job.r0        = s1_r0;
  assign push_job.c0        = s1_c0;
  assign push_job.wm1_0     = s1_wm1_0;
  assign push_job.eol       = s1_eol;
  assign push_job.last_row  = s1_lrow;
endmodule

// ===== hw/rtl/bbd_queue.sv =====
// Short job queue between front end and back end.
`timescale 1ns / 1ps
module bbd_queue #(
  parameter int DEPTH = bbd_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bbd_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       not_empty,
  output bbd_pkg::job_t              head,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);

  bbd_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + $bits(count)'(push) - $bits(count)'(pop);
    end
  end
endmodule

// ===== hw/rtl/bbd_back.sv =====
// Back end: walks each job's emits, interpolates and holds the output register.
`timescale 1ns / 1ps
module bbd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [1:0]                bayer_order,
  input  logic                      q_not_empty,
  input  bbd_pkg::job_t             q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbd_pkg::OUT_W-1:0] red,
  output logic [bbd_pkg::OUT_W-1:0] green,
  output logic [bbd_pkg::OUT_W-1:0] blue,
  output logic                      frame_end,
  output logic                      run_end
);
  localparam int PW = bbd_pkg::PIX_W;

  bbd_pkg::job_t cur;
  logic [3:0]    rem, rem_next, pick;
  logic          advance, load;
  logic          odd, late;
  logic [1:0]    ru, rc, rd, cl, cc, cr;
  logic [PW-1:0] ctr, rv, gv, bv;
  logic [PW:0]   hsum, vsum;
  logic [PW+1:0] dsum, cross_s, diag_s;
  logic [PW-1:0] cross_avg, diag, hmean, vmean;
  logic [1:0]    pos;

  assign pick     = rem & (~rem + 4'd1);
  assign advance  = (rem != '0) && (!out_valid || !out_stall);
  assign rem_next = rem & ~pick;
  assign load     = q_not_empty && ((rem == '0) || (advance && rem_next == '0));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= {q_head.eol & q_head.last_row, q_head.last_row, q_head.eol, 1'b1};
    end else if (advance) begin
      rem <= rem_next;
    end
    if (load) begin
      cur <= q_head;
    end
  end

  // emit kinds: plain, right-edge extra, last-row extra, last-row right-edge extra
  assign odd  = pick[1] | pick[3];
  assign late = pick[2] | pick[3];

  always_comb begin
    ru = late ? 2'd1 : (cur.ru_mirror ? 2'd2 : 2'd0);
    rc = late ? 2'd2 : 2'd1;
    rd = late ? 2'd1 : 2'd2;
    cl = odd ? 2'd1 : (cur.cl_mirror ? 2'd2 : 2'd0);
    cc = odd ? 2'd2 : 2'd1;
    cr = odd ? 2'd1 : 2'd2;
    pos = {late ? cur.r0 : ~cur.r0, odd ? cur.wm1_0 : ~cur.c0};
  end

  always_comb begin
    ctr       = cur.win[rc][cc];
    hsum      = {1'b0, cur.win[rc][cl]} + {1'b0, cur.win[rc][cr]};
    vsum      = {1'b0, cur.win[ru][cc]} + {1'b0, cur.win[rd][cc]};
    dsum      = {2'b0, cur.win[ru][cl]} + {2'b0, cur.win[ru][cr]}
              + {2'b0, cur.win[rd][cl]} + {2'b0, cur.win[rd][cr]};
    cross_s   = {1'b0, hsum} + {1'b0, vsum} + (PW+2)'(2);
    diag_s    = dsum + (PW+2)'(2);
    cross_avg = cross_s[PW+1:2];
    diag      = diag_s[PW+1:2];
    hmean     = PW'((hsum + (PW+1)'(1)) >> 1);
    vmean     = PW'((vsum + (PW+1)'(1)) >> 1);
    case (bbd_pkg::color_at(bayer_order, pos))
      bbd_pkg::COL_RED: begin
        rv = ctr;   gv = cross_avg; bv = diag;
      end
      bbd_pkg::COL_GR: begin
        rv = hmean; gv = ctr;   bv = vmean;
      end
      bbd_pkg::COL_GB: begin
        rv = vmean; gv = ctr;   bv = hmean;
      end
      default: begin
        rv = diag;  gv = cross_avg; bv = ctr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      red       <= {rv, 2'b00};
      green     <= {gv, 2'b00};
      blue      <= {bv, 2'b00};
      frame_end <= pick[3];
      run_end   <= (rem_next == '0);
    end
  end
endmodule

// ===== hw/rtl/bilinear_bayer_demosaic_core.sv =====
// Top level of the bilinear 3x3 Bayer demosaic core.
`timescale 1ns / 1ps
// A result passes the stage-1 registers, job queue, current-job and output registers.
// Throughput: one item per cycle while each emits one result and out_stall is low; the
//   back end then sends one result per cycle; right-edge and last-row items emit more.
// Reset (rst, synchronous): clears position, window, queue and output valid; loads
//   RGGB, 1920 x 1080. Line stores are not cleared; border mirroring never reads them.
module bilinear_bayer_demosaic_core #(
  parameter int MAX_WIDTH  = bbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbd_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_en,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bbd_pkg::RAW_W-1:0]       raw_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bbd_pkg::OUT_W-1:0]       red,
  output logic [bbd_pkg::OUT_W-1:0]       green,
  output logic [bbd_pkg::OUT_W-1:0]       blue,
  output logic                            frame_end,
  output logic                            run_end
);
  localparam int WD = $clog2(MAX_WIDTH+1);
  localparam int HD = $clog2(MAX_HEIGHT+1);
  localparam int QD = bbd_pkg::QUEUE_DEPTH;
  localparam int QC = $clog2(QD+1);

  logic [1:0]                bayer_order;
  logic [bbd_pkg::DIM_W-1:0] image_width, image_height;
  logic [WD-1:0]             width_eff;
  logic [HD-1:0]             height_eff;
  logic                      restart, accept;
  logic                      front_busy, push, pop, q_not_empty;
  logic [QC-1:0]             q_count;
  bbd_pkg::job_t             push_job, q_head;

  // Configuration registers; a size write restarts the frame position.
  always_ff @(posedge clk) begin
    if (rst) begin
      bayer_order  <= '0;
      image_width  <= bbd_pkg::DIM_W'(1920);
      image_height <= bbd_pkg::DIM_W'(1080);
    end else if (cfg_en) begin
      case (cfg_index)
        bbd_pkg::REG_BAYER_ORDER:  bayer_order  <= cfg_data[1:0];
        bbd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        bbd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_en && ((cfg_index == bbd_pkg::REG_IMAGE_WIDTH) ||
                              (cfg_index == bbd_pkg::REG_IMAGE_HEIGHT));

  // Saturate the frame size to [2, MAX].
  always_comb begin
    if (image_width < bbd_pkg::DIM_W'(2)) begin
      width_eff = WD'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = WD'(MAX_WIDTH);
    end else begin
      width_eff = WD'(image_width);
    end
    if (image_height < bbd_pkg::DIM_W'(2)) begin
      height_eff = HD'(2);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HD'(MAX_HEIGHT);
    end else begin
      height_eff = HD'(image_height);
    end
  end

  // Hold input whenever the queue could not absorb the item in flight plus a new one.
  assign in_stall = (32'(q_count) + 32'(front_busy)) >= 32'(QD);
  assign accept   = in_valid && !in_stall;

  bbd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .raw_pixel(raw_pixel), .restart(restart),
    .width_eff(width_eff), .height_eff(height_eff), .busy(front_busy),
    .push(push), .push_job(push_job)
  );

  bbd_queue #(.DEPTH(QD)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .pop(pop),
    .not_empty(q_not_empty), .head(q_head), .count(q_count)
  );

  bbd_back u_back (
    .clk(clk), .rst(rst), .bayer_order(bayer_order), .q_not_empty(q_not_empty),
    .q_head(q_head), .q_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .frame_end(frame_end), .run_end(run_end)
  );
endmodule

// ===== tb/bilinear_bayer_demosaic_core_tb.sv =====
// Self-checking testbench for the bilinear Bayer demosaic core: directed table, then random frames.
`timescale 1ns / 1ps
module bilinear_bayer_demosaic_core_tb;
  // register index past the end of the list; writes to it are dropped
  localparam logic [bbd_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // one interpolated pixel as it leaves the block
  typedef struct {
    logic [bbd_pkg::OUT_W-1:0] red;
    logic [bbd_pkg::OUT_W-1:0] green;
    logic [bbd_pkg::OUT_W-1:0] blue;
    logic                      frame_end;
    logic                      run_end;
  } rgb_px_t;

  // a row of the directed table; fixed rows carry the color typed in by hand
  typedef struct {
    logic [bbd_pkg::RAW_W-1:0] raw;
    bit                        fixed;
    logic [bbd_pkg::OUT_W-1:0] color;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_en = 1'b0;
  logic [bbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbd_pkg::DIM_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [bbd_pkg::RAW_W-1:0]     raw_pixel = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bbd_pkg::OUT_W-1:0]     red, green, blue;
  logic                          frame_end, run_end;

  bilinear_bayer_demosaic_core dut (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .raw_pixel(raw_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue),
    .frame_end(frame_end), .run_end(run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the demosaic state
  logic [bbd_pkg::PIX_W-1:0] upper_mem [bbd_pkg::DEF_MAX_WIDTH];
  logic [bbd_pkg::PIX_W-1:0] middle_mem [bbd_pkg::DEF_MAX_WIDTH];
  logic [bbd_pkg::PIX_W-1:0] win [3][3];
  int unsigned               col_pos, row_pos;
  logic [1:0]                order_reg;
  logic [bbd_pkg::DIM_W-1:0] width_reg, height_reg;

  rgb_px_t pending_px[$];
  int      errors = 0;
  int      px_seen = 0;
  bit      idle_on = 1'b1;

  // Interpolate one pixel from the window rows/columns given
  function automatic rgb_px_t interp_px(int ru, int rc, int rd, int cl, int cc, int cr,
                                        int prow, int pcol, bit fend);
    int unsigned     ctr, hsum, vsum, dsum, crs, dia, hm, vm, rv, gv, bv;
    bbd_pkg::color_t kind;
    rgb_px_t         p;
    ctr  = win[rc][cc];
    hsum = win[rc][cl] + win[rc][cr];
    vsum = win[ru][cc] + win[rd][cc];
    dsum = win[ru][cl] + win[ru][cr] + win[rd][cl] + win[rd][cr];
    crs  = (hsum + vsum + 2) >> 2;
    dia  = (dsum + 2) >> 2;
    hm   = (hsum + 1) >> 1;
    vm   = (vsum + 1) >> 1;
    kind = bbd_pkg::color_t'(order_reg ^ {prow[0], pcol[0]});
    case (kind)
      bbd_pkg::COL_RED: begin rv = ctr; gv = crs; bv = dia; end
      bbd_pkg::COL_GR:  begin rv = hm;  gv = ctr; bv = vm;  end
      bbd_pkg::COL_GB:  begin rv = vm;  gv = ctr; bv = hm;  end
      default: begin rv = dia; gv = crs; bv = ctr; end
    endcase
    p.red       = bbd_pkg::OUT_W'(rv << 2);
    p.green     = bbd_pkg::OUT_W'(gv << 2);
    p.blue      = bbd_pkg::OUT_W'(bv << 2);
    p.frame_end = fend;
    p.run_end   = 1'b0;
    return p;
  endfunction

  function automatic int unsigned clamp_dim(logic [bbd_pkg::DIM_W-1:0] v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  // Append one expected pixel behind the ones already waiting
  function automatic void add_expected(rgb_px_t px);
    pending_px = {pending_px, px};
  endfunction

  // Advance the shadow state by one accepted item and queue the pixels it emits
  function automatic int demosaic_predict(logic [bbd_pkg::RAW_W-1:0] raw);
    int unsigned               w, h, c, r;
    int                        k, cl, ru;
    logic [bbd_pkg::PIX_W-1:0] pix, u, m;
    rgb_px_t                   res [4];
    w = clamp_dim(width_reg, bbd_pkg::DEF_MAX_WIDTH);
    h = clamp_dim(height_reg, bbd_pkg::DEF_MAX_HEIGHT);
    c = col_pos;
    r = row_pos;
    k = 0;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    pix = raw[bbd_pkg::RAW_W-1:bbd_pkg::RAW_W-bbd_pkg::PIX_W];
    u = upper_mem[c];
    m = middle_mem[c];
    upper_mem[c]  = m;
    middle_mem[c] = pix;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = u;
    win[1][2] = m;
    win[2][2] = pix;
    if (r >= 1 && c >= 1) begin
      // mirror the edge neighbours on the first column and first row
      cl = (c == 1) ? 2 : 0;
      ru = (r == 1) ? 2 : 0;
      res[k++] = interp_px(ru, 1, 2, cl, 1, 2, r - 1, c - 1, 1'b0);
      if (c == w - 1) res[k++] = interp_px(ru, 1, 2, 1, 2, 1, r - 1, w - 1, 1'b0);
      if (r == h - 1) begin
        res[k++] = interp_px(1, 2, 1, cl, 1, 2, r, c - 1, 1'b0);
        if (c == w - 1) res[k++] = interp_px(1, 2, 1, 1, 2, 1, r, w - 1, 1'b1);
      end
    end
    if (k > 0) res[k-1].run_end = 1'b1;
    for (int i = 0; i < k; i++) add_expected(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
    return k;
  endfunction

  // Check every accepted pixel against the oldest expectation
  always @(posedge clk) begin
    rgb_px_t e;
    if (!rst && out_valid && !out_stall) begin
      px_seen <= px_seen + 1;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected pixel r=%h g=%h b=%h", $time, red, green, blue);
        errors++;
      end else begin
        e = pending_px.pop_front();
        if (red !== e.red) begin
          $display("%0t: red exp %h got %h", $time, e.red, red); errors++;
        end
        if (green !== e.green) begin
          $display("%0t: green exp %h got %h", $time, e.green, green); errors++;
        end
        if (blue !== e.blue) begin
          $display("%0t: blue exp %h got %h", $time, e.blue, blue); errors++;
        end
        if (frame_end !== e.frame_end) begin
          $display("%0t: frame_end exp %b got %b", $time, e.frame_end, frame_end); errors++;
        end
        if (run_end !== e.run_end) begin
          $display("%0t: run_end exp %b got %b", $time, e.run_end, run_end); errors++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to fill the block
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && px_seen >= 30) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one item after an optional idle gap, hold it until accepted, then predict
  task automatic send_px(logic [bbd_pkg::RAW_W-1:0] v, output int n);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_pixel <= v;
    do @(posedge clk); while (in_stall);
    n = demosaic_predict(v);
  endtask

  // Drain: drop valid, wait for every pixel, then let in-flight items settle
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [bbd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bbd_pkg::DIM_W-1:0] val);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      bbd_pkg::REG_BAYER_ORDER: order_reg = val[1:0];
      bbd_pkg::REG_IMAGE_WIDTH: begin width_reg = val; col_pos = 0; row_pos = 0; end
      bbd_pkg::REG_IMAGE_HEIGHT: begin height_reg = val; col_pos = 0; row_pos = 0; end
      default: ;
    endcase
  endtask

  function automatic logic [bbd_pkg::RAW_W-1:0] rand_raw();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return bbd_pkg::RAW_W'($urandom_range(0, 65535));
  endfunction

  // Directed frames on a 2x2 image: saturated, zero, dropped low bits, then patterns
  stim_row_t dir_tab [20] = '{
    '{16'hFFFF, 1, 16'hFFFC}, '{16'hFFFF, 1, 16'hFFFC},
    '{16'hFFFF, 1, 16'hFFFC}, '{16'hFFFF, 1, 16'hFFFC},
    '{16'h0000, 1, 16'h0000}, '{16'h0000, 1, 16'h0000},
    '{16'h0000, 1, 16'h0000}, '{16'h0000, 1, 16'h0000},
    '{16'h0003, 1, 16'h0000}, '{16'h0003, 1, 16'h0000},
    '{16'h0003, 1, 16'h0000}, '{16'h0003, 1, 16'h0000},
    '{16'h0004, 0, 16'h0000}, '{16'h8000, 0, 16'h0000},
    '{16'h7FFC, 0, 16'h0000}, '{16'hFFFB, 0, 16'h0000},
    '{16'hAAA8, 0, 16'h0000}, '{16'h5554, 0, 16'h0000},
    '{16'h1234, 0, 16'h0000}, '{16'hFFFF, 0, 16'h0000}
  };

  initial begin
    int n, items;
    for (int i = 0; i < bbd_pkg::DEF_MAX_WIDTH; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_pos = 0; row_pos = 0;
    order_reg = 2'd0; width_reg = 13'd1920; height_reg = 13'd1080;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // a few row-zero items at the reset size: no pixels may come out
    for (int i = 0; i < 4; i++) send_px(rand_raw(), n);
    drain();

    write_reg(bbd_pkg::REG_BAYER_ORDER, 13'd0);
    write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'd2);
    write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'd2);
    foreach (dir_tab[i]) begin
      send_px(dir_tab[i].raw, n);
      // override the color of hand-checked rows; the flags still come from prediction
      for (int j = pending_px.size() - n; j < pending_px.size(); j++) begin
        if (dir_tab[i].fixed) begin
          pending_px[j].red   = dir_tab[i].color;
          pending_px[j].green = dir_tab[i].color;
          pending_px[j].blue  = dir_tab[i].color;
        end
      end
    end
    drain();

    // Random phases; some only change the order so the frame carries on
    for (int p = 0; p < 12; p++) begin
      if (p == 11) idle_on = 1'b0;
      write_reg(bbd_pkg::REG_BAYER_ORDER, 13'($urandom_range(0, 3)));
      case (p)
        3: begin
          write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'd1);
          write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
        end
        5: begin
          write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'd0);
          write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'd1);
        end
        7: begin
          write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
          write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'd2);
        end
        9: begin
          write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'd4096);
          write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'd4096);
        end
        2, 6, 10: write_reg(REG_NONE, 13'($urandom_range(0, 8191)));
        default: begin
          write_reg(bbd_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(2, 7)));
          write_reg(bbd_pkg::REG_IMAGE_HEIGHT, 13'($urandom_range(2, 5)));
        end
      endcase
      items = (p == 7 || p == 9) ? 12 : 38;
      for (int i = 0; i < items; i++) send_px(rand_raw(), n);
      drain();
    end

    if (errors == 0 && pending_px.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_ram.sv
hw/rtl/bbd_front.sv
hw/rtl/bbd_queue.sv
hw/rtl/bbd_back.sv
hw/rtl/bilinear_bayer_demosaic_core.sv
tb/bilinear_bayer_demosaic_core_tb.sv
